FILE: hw/rtl/pmfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmfa_pkg
// Shared types and fixed field widths of the paged memory frame allocator.
// ----------------------------------------------------------------------------
package pmfa_pkg;

  localparam int KIND_W     = 2;
  localparam int PID_W      = 4;
  localparam int SIZE_W     = 21;
  localparam int VA_W       = 20;
  localparam int BYTE_W     = 8;
  localparam int IN_DATA_W  = 56;  // pid, size, address, byte = 53 bits, byte padded
  localparam int OUT_DATA_W = 32;  // start, byte = 28 bits, byte padded
  localparam int SUM_W      = SIZE_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic [VA_W-1:0]   region_start;
    logic              failed;
  } result_t;

endpackage

FILE: hw/rtl/pmfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmfa_ram
// Single-port synchronous RAM, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module pmfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

FILE: hw/rtl/pmfa_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmfa_out_reg
// Result holding register between the controller and the output stream.
// ----------------------------------------------------------------------------
module pmfa_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  pmfa_pkg::result_t  res,
  output logic               can_load,
  output logic               tvalid,
  input  logic               tready,
  output pmfa_pkg::result_t  res_q
);

  // free when empty or being drained this cycle
  assign can_load = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load && can_load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_q <= res;
    end
  end

endmodule

FILE: hw/rtl/paged_mmu_frame_allocator_unit.sv
`timescale 1ns / 1ps
// Read: XLATE, LOOK (map lookup), BYTE (byte RAM read); write: XLATE, then LOOK
//   (map lookup and byte RAM write). Allocate: one frame owner read and check
//   per frame scanned. Free: walk of the frame chain, unmapping, break pointer.
// One item in flight; the next is accepted while a result waits at the output.
// After reset a clearing pass of max(NUM_FRAMES << OFFSET_BITS, page map depth)
//   addresses clears byte, owner, page map RAMs; no item is accepted until it ends.
// ----------------------------------------------------------------------------
// paged_mmu_frame_allocator_unit
// Per-process paged memory manager: frame allocation, free, byte access.
// ----------------------------------------------------------------------------
module paged_mmu_frame_allocator_unit #(
  parameter int OFFSET_BITS     = 10,
  parameter int NUM_FRAMES      = 1024,
  parameter int SEG_INDEX_BITS  = 5,
  parameter int PAGE_INDEX_BITS = 5,
  parameter int MAX_PROCS       = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // process_id, alloc_bytes, virt_address, write_byte (lowest first)
  input  logic [pmfa_pkg::IN_DATA_W-1:0]   s_tdata,
  // kind
  input  logic [pmfa_pkg::KIND_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // region_start, read_byte (lowest first)
  output logic [pmfa_pkg::OUT_DATA_W-1:0]  m_tdata,
  // failed
  output logic                             m_tuser
);

  localparam int VPN_BITS  = SEG_INDEX_BITS + PAGE_INDEX_BITS;
  localparam int FB        = $clog2(NUM_FRAMES);
  localparam int LW        = $clog2(NUM_FRAMES + 1);
  localparam int PB        = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int PM_AW     = PB + VPN_BITS;
  localparam int PM_DEPTH  = 1 << PM_AW;
  localparam int BY_AW     = FB + OFFSET_BITS;
  localparam int BY_DEPTH  = NUM_FRAMES << OFFSET_BITS;
  localparam longint RAM_BYTES = longint'(NUM_FRAMES) << OFFSET_BITS;
  localparam longint VSPACE    = longint'(1) << (VPN_BITS + OFFSET_BITS);
  localparam longint LIMIT     = (RAM_BYTES < VSPACE) ? RAM_BYTES : VSPACE;
  localparam int BP_W      = $clog2(LIMIT + 1);
  localparam int SUM_W     = pmfa_pkg::SUM_W;
  localparam int EW        = ((BP_W > SUM_W) ? BP_W : SUM_W) + 1;
  localparam int UW        = ((VPN_BITS > LW) ? VPN_BITS : LW) + 1;
  localparam int DW        = LW + OFFSET_BITS;
  localparam int CLR_N     = (BY_DEPTH > PM_DEPTH) ? BY_DEPTH : PM_DEPTH;
  localparam int CLW       = $clog2(CLR_N + 1);
  localparam int VA_W      = pmfa_pkg::VA_W;
  localparam int BYTE_W    = pmfa_pkg::BYTE_W;

  typedef enum logic [13:0] {
    ST_CLEAR  = 14'b00000000000001,
    ST_IDLE   = 14'b00000000000010,
    ST_XLATE  = 14'b00000000000100,
    ST_LOOK   = 14'b00000000001000,
    ST_BYTE   = 14'b00000000010000,
    ST_CHECK  = 14'b00000000100000,
    ST_AS_RD  = 14'b00000001000000,
    ST_AS_WR  = 14'b00000010000000,
    ST_A_END  = 14'b00000100000000,
    ST_FW_RD  = 14'b00001000000000,
    ST_FW_WR  = 14'b00010000000000,
    ST_F_UNMP = 14'b00100000000000,
    ST_F_BP   = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_t;

  state_t state;

  // latched item
  pmfa_pkg::kind_t         kind_q;
  logic [PB-1:0]           proc_q;
  logic [pmfa_pkg::SIZE_W-1:0] size_q;
  logic [VA_W-1:0]         va_q;
  logic [BYTE_W-1:0]       data_q;
  logic [pmfa_pkg::PID_W-1:0] pid_q;

  // working registers
  logic [BP_W-1:0]  bp_q [MAX_PROCS];
  logic [BP_W-1:0]  start_q;
  logic [SUM_W-1:0] pages_q;
  logic [SUM_W-1:0] k_q;
  logic [FB-1:0]    scan_q;
  logic [FB-1:0]    prev_q;
  logic [LW-1:0]    fr_q;
  logic [LW-1:0]    cnt_q;
  logic [LW-1:0]    idx_q;
  logic [LW-1:0]    free_cnt;
  logic [CLW-1:0]   clr_q;
  pmfa_pkg::result_t res_q;

  // memory ports
  logic               by_we, ow_we, lk_we, pm_we;
  logic [BY_AW-1:0]   by_addr;
  logic [FB-1:0]      ow_addr, lk_addr;
  logic [PM_AW-1:0]   pm_addr;
  logic [BYTE_W-1:0]  by_wdata, by_rdata;
  logic [pmfa_pkg::PID_W-1:0] ow_wdata, ow_rdata;
  logic [LW-1:0]      lk_wdata, lk_rdata, pm_wdata, pm_rdata;

  logic out_load, out_can;
  pmfa_pkg::result_t out_res;

  // unpack the input item
  logic [pmfa_pkg::PID_W-1:0]  in_pid;
  logic [pmfa_pkg::SIZE_W-1:0] in_size;
  logic [VA_W-1:0]             in_va;
  logic [BYTE_W-1:0]           in_byte;
  assign in_pid  = s_tdata[3:0];
  assign in_size = s_tdata[24:4];
  assign in_va   = s_tdata[44:25];
  assign in_byte = s_tdata[52:45];

  assign s_tready = (state == ST_IDLE);

  // address decode of the latched item
  logic [VA_W-1:0]     va_sh;
  logic [VPN_BITS-1:0] vpn;
  logic [LW-1:0]       entry_m1;
  logic                entry_bad;
  assign va_sh     = va_q >> OFFSET_BITS;
  assign vpn       = VPN_BITS'(va_sh);
  assign entry_bad = (pm_rdata == '0) || (pm_rdata > LW'(NUM_FRAMES));
  assign entry_m1  = pm_rdata - LW'(1);

  // allocation checks
  logic [SUM_W-1:0] sum_sz, rounded, pages;
  logic [EW-1:0]    end_addr;
  logic [BP_W-1:0]  bp_cur;
  assign bp_cur   = bp_q[proc_q];
  assign sum_sz   = SUM_W'(size_q) + SUM_W'((1 << OFFSET_BITS) - 1);
  assign pages    = sum_sz >> OFFSET_BITS;
  assign rounded  = pages << OFFSET_BITS;
  assign end_addr = EW'(bp_cur) + EW'(rounded);

  // page numbers for mapping and unmapping
  logic [BP_W-1:0]     start_pg;
  logic [VPN_BITS-1:0] vpn_alloc;
  logic [UW-1:0]       vpn_unmap;
  assign start_pg  = start_q >> OFFSET_BITS;
  assign vpn_alloc = VPN_BITS'(start_pg) + VPN_BITS'(k_q);
  assign vpn_unmap = UW'(vpn) + UW'(idx_q);

  // break pointer after a free
  logic [DW-1:0] dec;
  assign dec = DW'(cnt_q) << OFFSET_BITS;

  // memory port control
  always_comb begin
    by_we = 1'b0; ow_we = 1'b0; lk_we = 1'b0; pm_we = 1'b0;
    by_addr = {FB'(entry_m1), va_q[OFFSET_BITS-1:0]};
    by_wdata = data_q;
    ow_addr = scan_q;
    ow_wdata = pid_q;
    lk_addr = prev_q;
    lk_wdata = LW'(scan_q);
    pm_addr = {proc_q, vpn};
    pm_wdata = '0;
    case (state)
      ST_CLEAR: begin
        by_addr  = BY_AW'(clr_q);
        ow_addr  = FB'(clr_q);
        pm_addr  = PM_AW'(clr_q);
        by_wdata = '0;
        ow_wdata = '0;
        by_we    = (clr_q < CLW'(BY_DEPTH));
        ow_we    = (clr_q < CLW'(NUM_FRAMES));
        pm_we    = (clr_q < CLW'(PM_DEPTH));
      end
      ST_LOOK: begin
        by_we = !entry_bad && (kind_q == pmfa_pkg::KIND_WRITE);
      end
      ST_AS_WR: begin
        if (ow_rdata == '0) begin
          ow_we    = 1'b1;
          lk_we    = (k_q != '0);
          pm_we    = 1'b1;
          pm_addr  = {proc_q, vpn_alloc};
          pm_wdata = LW'(scan_q) + LW'(1);
        end
      end
      ST_A_END: begin
        lk_we    = 1'b1;
        lk_wdata = LW'(NUM_FRAMES);
      end
      ST_FW_RD: begin
        ow_addr = FB'(fr_q);
        lk_addr = FB'(fr_q);
      end
      ST_FW_WR: begin
        ow_addr  = FB'(fr_q);
        ow_wdata = '0;
        ow_we    = 1'b1;
      end
      ST_F_UNMP: begin
        pm_addr = {proc_q, VPN_BITS'(vpn_unmap)};
        pm_we   = (idx_q < cnt_q) && (vpn_unmap < UW'(1 << VPN_BITS));
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_q    <= '0;
      free_cnt <= LW'(NUM_FRAMES);
      for (int i = 0; i < MAX_PROCS; i++) begin
        bp_q[i] <= '0;
      end
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_q <= clr_q + CLW'(1);
          if (clr_q == CLW'(CLR_N - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            kind_q <= pmfa_pkg::kind_t'(s_tuser);
            pid_q  <= in_pid;
            proc_q <= PB'(in_pid - pmfa_pkg::PID_W'(1));
            size_q <= in_size;
            va_q   <= in_va;
            data_q <= in_byte;
            res_q  <= '{read_byte: '0, region_start: '0, failed: 1'b1};
            if (in_pid == '0 || in_pid > pmfa_pkg::PID_W'(MAX_PROCS)) begin
              state <= ST_DONE;
            end else if (s_tuser == pmfa_pkg::KIND_ALLOC) begin
              state <= ST_CHECK;
            end else begin
              state <= ST_XLATE;
            end
          end
        end
        ST_XLATE: begin
          state <= ST_LOOK;
        end
        ST_LOOK: begin
          fr_q  <= entry_m1;
          cnt_q <= '0;
          if (entry_bad) begin
            state <= ST_DONE;
          end else if (kind_q == pmfa_pkg::KIND_FREE) begin
            state <= ST_FW_RD;
          end else if (kind_q == pmfa_pkg::KIND_READ) begin
            state <= ST_BYTE;
          end else begin
            res_q.failed <= 1'b0;
            state <= ST_DONE;
          end
        end
        ST_BYTE: begin
          res_q.failed    <= 1'b0;
          res_q.read_byte <= by_rdata;
          state <= ST_DONE;
        end
        ST_CHECK: begin
          k_q     <= '0;
          scan_q  <= '0;
          pages_q <= pages;
          start_q <= bp_cur;
          if (size_q == '0 || SUM_W'(free_cnt) < pages || end_addr > EW'(LIMIT)) begin
            state <= ST_DONE;
          end else begin
            bp_q[proc_q] <= BP_W'(end_addr);
            free_cnt     <= free_cnt - LW'(pages);
            state        <= ST_AS_RD;
          end
        end
        ST_AS_RD: begin
          state <= ST_AS_WR;
        end
        ST_AS_WR: begin
          scan_q <= scan_q + FB'(1);
          state  <= ST_AS_RD;
          if (ow_rdata == '0) begin
            prev_q <= scan_q;
            k_q    <= k_q + SUM_W'(1);
            if (k_q + SUM_W'(1) == pages_q) begin
              state <= ST_A_END;
            end
          end
        end
        ST_A_END: begin
          res_q.failed       <= 1'b0;
          res_q.region_start <= VA_W'(start_q);
          state <= ST_DONE;
        end
        ST_FW_RD: begin
          idx_q <= '0;
          if (fr_q < LW'(NUM_FRAMES) && cnt_q < LW'(NUM_FRAMES)) begin
            state <= ST_FW_WR;
          end else begin
            state <= ST_F_UNMP;
          end
        end
        ST_FW_WR: begin
          if (ow_rdata != '0) begin
            free_cnt <= free_cnt + LW'(1);
          end
          cnt_q <= cnt_q + LW'(1);
          fr_q  <= lk_rdata;
          state <= ST_FW_RD;
        end
        ST_F_UNMP: begin
          idx_q <= idx_q + LW'(1);
          if (!pm_we) begin
            state <= ST_F_BP;
          end
        end
        ST_F_BP: begin
          bp_q[proc_q] <= (DW'(bp_cur) >= dec) ? BP_W'(DW'(bp_cur) - dec) : '0;
          res_q.failed <= 1'b0;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_can) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_load = (state == ST_DONE);

  pmfa_ram #(.WIDTH(BYTE_W), .DEPTH(BY_DEPTH), .AW(BY_AW)) u_byte_ram (
    .clk(clk), .we(by_we), .addr(by_addr), .wdata(by_wdata), .rdata(by_rdata)
  );

  pmfa_ram #(.WIDTH(pmfa_pkg::PID_W), .DEPTH(NUM_FRAMES), .AW(FB)) u_owner_ram (
    .clk(clk), .we(ow_we), .addr(ow_addr), .wdata(ow_wdata), .rdata(ow_rdata)
  );

  pmfa_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES), .AW(FB)) u_link_ram (
    .clk(clk), .we(lk_we), .addr(lk_addr), .wdata(lk_wdata), .rdata(lk_rdata)
  );

  pmfa_ram #(.WIDTH(LW), .DEPTH(PM_DEPTH), .AW(PM_AW)) u_page_map (
    .clk(clk), .we(pm_we), .addr(pm_addr), .wdata(pm_wdata), .rdata(pm_rdata)
  );

  pmfa_out_reg u_out (
    .clk(clk), .rst(rst), .load(out_load), .res(res_q), .can_load(out_can),
    .tvalid(m_tvalid), .tready(m_tready), .res_q(out_res)
  );

  assign m_tuser = out_res.failed;
  assign m_tdata = {4'b0000, out_res.read_byte, out_res.region_start};

endmodule
